// ===== sv/tpvot_pkg.sv =====
// ----------------------------------------------------------------------------
// tpvot_pkg
// Types and constants for the two-phase version order tracker.
// ----------------------------------------------------------------------------
package tpvot_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VER_W       = 31;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 3;

    // actions
    localparam logic [ACT_W-1:0] ACT_ADD_DATA = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_META = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIN_META = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIN_DATA = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_HEAD = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VER_W-1:0] version;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              head_valid;
        logic [VER_W-1:0]  head_version;
        logic              may_run_data;
        logic              may_run_meta;
    } out_item_t;

endpackage

// ===== sv/two_phase_version_order_tracker.sv =====
// ----------------------------------------------------------------------------
// two_phase_version_order_tracker
// Table of pending versions with metadata/data finished marks, head tracking.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_data : in_item_t  (action, version)
//  m_      | out | m_valid / m_ready  | m_data : out_item_t (status, head, flags)
//
//  After a transfer the block is not ready again until it has scanned the
//  table twice, one slot per cycle through the shared compare unit: once
//  for match/free/head, once more for the new head.
//  The result sits in an output register; a stalled m_ready only holds the
//  block at the end of the second scan. aresetn (synchronous) empties the
//  table at once.
// ----------------------------------------------------------------------------
module two_phase_version_order_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tpvot_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tpvot_pkg::out_item_t m_data
);
    import tpvot_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    in_item_t         item_reg;

    logic             used_reg [TABLE_DEPTH];
    logic [VER_W-1:0] ver_reg  [TABLE_DEPTH];
    logic             meta_reg [TABLE_DEPTH];
    logic             data_reg [TABLE_DEPTH];

    // scan results
    logic             any_reg, any_next;
    logic [VER_W-1:0] best_reg, best_next;
    logic             match_reg, match_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // result held between apply and output load
    logic [STAT_W-1:0] status_reg, status_next;
    logic              rd_reg, rd_next;
    logic              rm_reg, rm_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    // table write controls
    logic             wr_used_en, wr_used_val;
    logic             wr_ins_en;
    logic             wr_meta_en, wr_meta_val;
    logic             wr_data_en, wr_data_val;
    logic [IDX_W-1:0] wr_idx;

    // shared compare unit, on the slot under the scan index
    logic             cur_used;
    logic [VER_W-1:0] cur_ver;
    logic             cur_lt, cur_eq, take_min;

    logic             v_below, v_head, last_slot, out_free;

    assign cur_used  = used_reg[idx_reg];
    assign cur_ver   = ver_reg[idx_reg];
    assign cur_lt    = cur_ver < best_reg;
    assign cur_eq    = cur_ver == item_reg.version;
    assign take_min  = cur_used && (!any_reg || cur_lt);
    assign last_slot = idx_reg == LAST_IDX;
    assign out_free  = !out_valid_reg || m_ready;

    assign v_below = item_reg.version < best_reg;
    assign v_head  = item_reg.version == best_reg;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        any_next       = any_reg;
        best_next      = best_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        rm_next        = rm_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_used_en     = 1'b0;
        wr_used_val    = 1'b0;
        wr_ins_en      = 1'b0;
        wr_meta_en     = 1'b0;
        wr_meta_val    = 1'b0;
        wr_data_en     = 1'b0;
        wr_data_val    = 1'b0;
        wr_idx         = match_idx_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                idx_next   = '0;
                any_next   = 1'b0;
                best_next  = '0;
                match_next = 1'b0;
                free_next  = 1'b0;
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (take_min) begin
                    any_next  = 1'b1;
                    best_next = cur_ver;
                end
                if (cur_used && cur_eq && !match_reg) begin
                    match_next     = 1'b1;
                    match_idx_next = idx_reg;
                end
                if (!cur_used && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (last_slot) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                status_next = ST_OK;
                rd_next     = 1'b0;
                rm_next     = 1'b0;
                case (item_reg.action) inside
                    ACT_ADD_DATA, ACT_ADD_META: begin
                        if (match_reg) begin
                            if (item_reg.action == ACT_ADD_DATA) begin
                                wr_data_en = 1'b1;
                            end else begin
                                wr_meta_en = 1'b1;
                            end
                        end else if (!free_reg) begin
                            status_next = ST_FULL;
                        end else begin
                            wr_idx      = free_idx_reg;
                            wr_used_en  = 1'b1;
                            wr_used_val = 1'b1;
                            wr_ins_en   = 1'b1;
                            wr_meta_en  = 1'b1;
                            wr_data_en  = 1'b1;
                            wr_meta_val = item_reg.action == ACT_ADD_DATA;
                            wr_data_val = item_reg.action != ACT_ADD_DATA;
                        end
                    end
                    ACT_FIN_META: begin
                        if (!match_reg) begin
                            status_next = ST_IGNORED;
                        end else if (!v_head) begin
                            status_next = ST_NOT_HEAD;
                        end else if (data_reg[match_idx_reg]) begin
                            wr_used_en = 1'b1;
                        end else begin
                            wr_meta_en  = 1'b1;
                            wr_meta_val = 1'b1;
                        end
                    end
                    ACT_FIN_DATA: begin
                        if (!any_reg || v_below) begin
                            status_next = ST_IGNORED;
                        end else if (!match_reg) begin
                            status_next = ST_MISSING;
                        end else if (meta_reg[match_idx_reg]) begin
                            wr_used_en = 1'b1;
                        end else begin
                            wr_data_en  = 1'b1;
                            wr_data_val = 1'b1;
                        end
                    end
                    ACT_QUERY: begin
                        if (!any_reg || v_below) begin
                            rd_next = 1'b1;
                            rm_next = 1'b1;
                        end else begin
                            if (!match_reg) begin
                                status_next = ST_MISSING;
                            end else begin
                                rd_next = meta_reg[match_idx_reg];
                            end
                            rm_next = v_head;
                        end
                    end
                    default: begin
                        status_next = ST_IGNORED;
                    end
                endcase
                // second pass finds the head of the updated table
                idx_next   = '0;
                any_next   = 1'b0;
                best_next  = '0;
                state_next = S_HEAD;
            end
            S_HEAD: begin
                if (!last_slot) begin
                    if (take_min) begin
                        any_next  = 1'b1;
                        best_next = cur_ver;
                    end
                    idx_next = idx_reg + 1'b1;
                end else if (out_free) begin
                    out_next.status       = status_reg;
                    out_next.head_valid   = any_reg || cur_used;
                    out_next.head_version = take_min ? cur_ver : best_reg;
                    out_next.may_run_data = rd_reg;
                    out_next.may_run_meta = rm_reg;
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                used_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_used_en) begin
                used_reg[wr_idx] <= wr_used_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        idx_reg       <= idx_next;
        any_reg       <= any_next;
        best_reg      <= best_next;
        match_reg     <= match_next;
        match_idx_reg <= match_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        status_reg    <= status_next;
        rd_reg        <= rd_next;
        rm_reg        <= rm_next;
        out_reg       <= out_next;
        if (wr_ins_en) begin
            ver_reg[wr_idx] <= item_reg.version;
        end
        if (wr_meta_en) begin
            meta_reg[wr_idx] <= wr_meta_val;
        end
        if (wr_data_en) begin
            data_reg[wr_idx] <= wr_data_val;
        end
    end

endmodule
